[design/gn2_pkg.sv]
// ----------------------------------------------------------------------------
// gn2_pkg: shared types, constants and helpers for the 2D gradient noise block
// Fixed-point widths, corner hash, gradient dot product and queue entry type.
// ----------------------------------------------------------------------------
package gn2_pkg;

	localparam int FRAC_BITS = 12;
	localparam int INT_BITS  = 16;
	localparam int COORD_W   = INT_BITS + FRAC_BITS;
	localparam int OUT_W     = FRAC_BITS + 3;

	// config port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_SEED = REG_IDX_W'(0);

	localparam int SEED_W = 8;
	localparam logic [SEED_W-1:0] SEED_RESET = SEED_W'(11);

	// corner hash
	localparam int HASH_W   = 3;
	localparam int HASH_MUL = 57;

	// datapath widths
	localparam int OFS_W    = FRAC_BITS + 1;        // signed corner offset
	localparam int DOT_W    = FRAC_BITS + 3;        // gradient dot, up to +/-2.0
	localparam int SQ_W     = 2 * FRAC_BITS;        // s*s
	localparam int CUBIC_W  = FRAC_BITS + 2;        // 3 - 2s
	localparam int FP_W     = 3 * FRAC_BITS + 2;    // fade product
	localparam int FADE_W   = FRAC_BITS + 1;        // fade weight in [0, 1]
	localparam int DIFF_W   = FRAC_BITS + 4;        // horizontal b - a
	localparam int LPROD_W  = DIFF_W + FADE_W + 1;
	localparam int LERP_W   = FRAC_BITS + 4;
	localparam int VDIFF_W  = LERP_W + 1;
	localparam int VPROD_W  = VDIFF_W + FADE_W + 1;
	localparam int RES_W    = FRAC_BITS + 5;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [HASH_W-1:0]    h00;
		logic [HASH_W-1:0]    h10;
		logic [HASH_W-1:0]    h01;
		logic [HASH_W-1:0]    h11;
		logic [FRAC_BITS-1:0] sx;
		logic [FRAC_BITS-1:0] sy;
	} gn2_entry_t;

	// gradient components per hash: (1,0) (-1,0) (0,1) (0,-1) (1,1) (-1,1) (1,-1) (-1,-1)
	localparam logic signed [1:0] GRAD_X [2**HASH_W] = '{
		2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1};
	localparam logic signed [1:0] GRAD_Y [2**HASH_W] = '{
		2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};

	// only the low hash bits survive the mod 256 / mod 8, so low cell bits suffice
	function automatic logic [HASH_W-1:0] corner_hash(
		logic [HASH_W-1:0] cx,
		logic [HASH_W-1:0] cy,
		logic [SEED_W-1:0] seed
	);
		logic [SEED_W-1:0] sum;
		sum = SEED_W'(cx) + SEED_W'(HASH_MUL) * SEED_W'(cy) + seed;
		return sum[HASH_W-1:0];
	endfunction

	function automatic logic signed [DOT_W-1:0] grad_term(
		logic signed [1:0]       g,
		logic signed [OFS_W-1:0] d
	);
		logic signed [DOT_W-1:0] de;
		de = DOT_W'(d);
		if (g > 0)
			return de;
		else if (g < 0)
			return -de;
		else
			return '0;
	endfunction

	function automatic logic signed [DOT_W-1:0] grad_dot(
		logic [HASH_W-1:0]       h,
		logic signed [OFS_W-1:0] dx,
		logic signed [OFS_W-1:0] dy
	);
		return grad_term(GRAD_X[h], dx) + grad_term(GRAD_Y[h], dy);
	endfunction

endpackage

[design/gn2_if.sv]
// ----------------------------------------------------------------------------
// gn2_if: valid/ready channels of the 2D gradient noise block
// Point channel (x_coord, y_coord) and noise result channel (noise_value).
// ----------------------------------------------------------------------------
interface gn2_point_if;
	import gn2_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] x_coord;
	logic [COORD_W-1:0] y_coord;

	modport source(output valid, output x_coord, output y_coord, input ready);
	modport sink(input valid, input x_coord, input y_coord, output ready);
endinterface

interface gn2_noise_if;
	import gn2_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] noise_value;

	modport source(output valid, output noise_value, input ready);
	modport sink(input valid, input noise_value, output ready);
endinterface

[design/gn2_front.sv]
// ----------------------------------------------------------------------------
// gn2_front: point intake, seed register and corner hashing
// Splits each point beat into cell and offset and pushes a queue entry.
// ----------------------------------------------------------------------------
module gn2_front (
	input  logic                          clk,
	input  logic                          arst_n,
	gn2_point_if.sink                     point,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gn2_pkg::PADDR_W-1:0]   paddr,
	input  logic [gn2_pkg::PDATA_W-1:0]   pwdata,
	output logic [gn2_pkg::PDATA_W-1:0]   prdata,
	input  logic                          fifo_full,
	output logic                          push,
	output gn2_pkg::gn2_entry_t           push_entry
);
	import gn2_pkg::*;

	logic [SEED_W-1:0]    seed_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [HASH_W-1:0]    cx;
	logic [HASH_W-1:0]    cy;
	logic [HASH_W-1:0]    cx1;
	logic [HASH_W-1:0]    cy1;

	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (psel && penable && pwrite && reg_idx == REG_SEED) begin
			seed_q <= pwdata[SEED_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_SEED)
			prdata = PDATA_W'(seed_q);
	end

	// low cell bits; +1 wraps, matching the hash's modulo
	assign cx  = point.x_coord[FRAC_BITS +: HASH_W];
	assign cy  = point.y_coord[FRAC_BITS +: HASH_W];
	assign cx1 = cx + HASH_W'(1);
	assign cy1 = cy + HASH_W'(1);

	always_comb begin
		push_entry.h00 = corner_hash(cx,  cy,  seed_q);
		push_entry.h10 = corner_hash(cx1, cy,  seed_q);
		push_entry.h01 = corner_hash(cx,  cy1, seed_q);
		push_entry.h11 = corner_hash(cx1, cy1, seed_q);
		push_entry.sx  = point.x_coord[FRAC_BITS-1:0];
		push_entry.sy  = point.y_coord[FRAC_BITS-1:0];
	end

	assign point.ready = !fifo_full;
	assign push        = point.valid && !fifo_full;

endmodule

[design/gn2_fifo.sv]
// ----------------------------------------------------------------------------
// gn2_fifo: short queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module gn2_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  gn2_pkg::gn2_entry_t  push_entry,
	input  logic                 pop,
	output gn2_pkg::gn2_entry_t  head,
	output logic                 full,
	output logic                 empty
);
	import gn2_pkg::*;

	gn2_entry_t            mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
					: wr_ptr_q + FIFO_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
					: rd_ptr_q + FIFO_PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + FIFO_CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - FIFO_CNT_W'(1);
		end
	end

endmodule

[design/gn2_back.sv]
// ----------------------------------------------------------------------------
// gn2_back: dot, fade and blend pipeline
// Eight stages; the whole pipe holds while the output beat is not taken.
// ----------------------------------------------------------------------------
module gn2_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gn2_pkg::gn2_entry_t  head,
	input  logic                 fifo_empty,
	output logic                 pop,
	gn2_noise_if.source          noise
);
	import gn2_pkg::*;

	localparam logic [CUBIC_W-1:0] THREE_ONE = CUBIC_W'(3) << FRAC_BITS;
	localparam logic [FP_W-1:0]    FADE_HALF = FP_W'(1) << (2 * FRAC_BITS - 1);
	localparam logic signed [LPROD_W-1:0] LHALF = LPROD_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [VPROD_W-1:0] VHALF = VPROD_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [RES_W-1:0]   LIM   = RES_W'(1) << (FRAC_BITS + 1);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// stage 1
	logic [FRAC_BITS-1:0]    sx_s1, sy_s1;
	logic [SQ_W-1:0]         sqx_s1, sqy_s1;
	logic signed [DOT_W-1:0] d00_s1, d10_s1, d01_s1, d11_s1;
	// stage 2
	logic [FP_W-1:0]         px_s2, py_s2;
	logic signed [DOT_W-1:0] d00_s2, d01_s2;
	logic signed [DIFF_W-1:0] dt_s2, db_s2;
	// stage 3
	logic [FADE_W-1:0]       fx_s3, fy_s3;
	logic signed [DOT_W-1:0] d00_s3, d01_s3;
	logic signed [DIFF_W-1:0] dt_s3, db_s3;
	// stage 4
	logic signed [LPROD_W-1:0] pt_s4, pb_s4;
	logic signed [DOT_W-1:0]   d00_s4, d01_s4;
	logic [FADE_W-1:0]         fy_s4;
	// stage 5
	logic signed [LERP_W-1:0] top_s5, bot_s5;
	logic [FADE_W-1:0]        fy_s5;
	// stage 6
	logic signed [LERP_W-1:0]  top_s6;
	logic signed [VDIFF_W-1:0] dv_s6;
	logic [FADE_W-1:0]         fy_s6;
	// stage 7
	logic signed [LERP_W-1:0]  top_s7;
	logic signed [VPROD_W-1:0] pv_s7;
	// stage 8 (output)
	logic signed [OUT_W-1:0]   noise_s8;

	// combinational helpers
	logic signed [OFS_W-1:0]   dx0, dx1, dy0, dy1;
	logic [CUBIC_W-1:0]        wx, wy;
	logic signed [LPROD_W-1:0] rt_sum, rb_sum;
	logic signed [VPROD_W-1:0] rv_sum;
	logic signed [RES_W-1:0]   res;

	assign en  = !v_s8 || noise.ready;
	assign pop = en && !fifo_empty;

	// offset to near corner is s, to far corner s - 1
	assign dx0 = $signed({1'b0, head.sx});
	assign dx1 = $signed({1'b1, head.sx});
	assign dy0 = $signed({1'b0, head.sy});
	assign dy1 = $signed({1'b1, head.sy});

	assign wx = THREE_ONE - (CUBIC_W'(sx_s1) << 1);
	assign wy = THREE_ONE - (CUBIC_W'(sy_s1) << 1);

	assign rt_sum = pt_s4 + LHALF;
	assign rb_sum = pb_s4 + LHALF;
	assign rv_sum = pv_s7 + VHALF;

	always_comb begin
		res = RES_W'(top_s7) + RES_W'(rv_sum >>> FRAC_BITS);
		if (res > LIM)
			res = LIM;
		else if (res < -LIM)
			res = -LIM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= !fifo_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: gradient dots and offset squares
			sx_s1  <= head.sx;
			sy_s1  <= head.sy;
			sqx_s1 <= SQ_W'(head.sx) * SQ_W'(head.sx);
			sqy_s1 <= SQ_W'(head.sy) * SQ_W'(head.sy);
			d00_s1 <= grad_dot(head.h00, dx0, dy0);
			d10_s1 <= grad_dot(head.h10, dx1, dy0);
			d01_s1 <= grad_dot(head.h01, dx0, dy1);
			d11_s1 <= grad_dot(head.h11, dx1, dy1);
			// s2: s^2 * (3 - 2s), horizontal differences
			px_s2  <= FP_W'(sqx_s1) * FP_W'(wx);
			py_s2  <= FP_W'(sqy_s1) * FP_W'(wy);
			d00_s2 <= d00_s1;
			d01_s2 <= d01_s1;
			dt_s2  <= DIFF_W'(d10_s1) - DIFF_W'(d00_s1);
			db_s2  <= DIFF_W'(d11_s1) - DIFF_W'(d01_s1);
			// s3: round fade weights
			fx_s3  <= FADE_W'((px_s2 + FADE_HALF) >> (2 * FRAC_BITS));
			fy_s3  <= FADE_W'((py_s2 + FADE_HALF) >> (2 * FRAC_BITS));
			d00_s3 <= d00_s2;
			d01_s3 <= d01_s2;
			dt_s3  <= dt_s2;
			db_s3  <= db_s2;
			// s4: horizontal weight products
			pt_s4  <= LPROD_W'(dt_s3) * $signed({1'b0, fx_s3});
			pb_s4  <= LPROD_W'(db_s3) * $signed({1'b0, fx_s3});
			d00_s4 <= d00_s3;
			d01_s4 <= d01_s3;
			fy_s4  <= fy_s3;
			// s5: top and bottom blends
			top_s5 <= LERP_W'(d00_s4) + LERP_W'(rt_sum >>> FRAC_BITS);
			bot_s5 <= LERP_W'(d01_s4) + LERP_W'(rb_sum >>> FRAC_BITS);
			fy_s5  <= fy_s4;
			// s6: vertical difference
			top_s6 <= top_s5;
			dv_s6  <= VDIFF_W'(bot_s5) - VDIFF_W'(top_s5);
			fy_s6  <= fy_s5;
			// s7: vertical weight product
			top_s7 <= top_s6;
			pv_s7  <= VPROD_W'(dv_s6) * $signed({1'b0, fy_s6});
			// s8: final blend, saturate
			noise_s8 <= OUT_W'(res);
		end
	end

	assign noise.valid       = v_s8;
	assign noise.noise_value = noise_s8;

endmodule

[design/gradient_noise_2d.sv]
// ----------------------------------------------------------------------------
// gradient_noise_2d: 2D gradient noise, one point per clock while the output is taken
// Top level: front end, entry queue and blend pipeline.
// ----------------------------------------------------------------------------
// Takes a point (x_coord, y_coord), each unsigned 16.12 fixed point, and returns
// one noise_value: signed, 12 fraction bits, saturated to [-2.0, +2.0]. The four
// cell corners are hashed as (cx + 57*cy + seed) mod 256 mod 8 to pick one of
// eight gradients; the corner dots are blended with the fade w*w*(3-2w), first
// along x, then along y, rounding half up at each step. Throughput is one point
// per clock while the output side is ready. An accepted point beat is written
// into the 4-entry queue, popped from it into the first of the eight blend
// stages and passes through them to the output register. The multiplier stages
// (fade cube, then the two blends) set the pipeline depth. The pipeline holds as
// a whole while an output beat waits; the queue keeps taking points until it is
// full. The only register is hash_seed at byte address 0 (reset 11); write it
// while no point is in flight.
// ----------------------------------------------------------------------------
module gradient_noise_2d (
	input  logic                          clk,
	input  logic                          arst_n,
	gn2_point_if.sink                     point,
	gn2_noise_if.source                   noise,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gn2_pkg::PADDR_W-1:0]   paddr,
	input  logic [gn2_pkg::PDATA_W-1:0]   pwdata,
	output logic [gn2_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import gn2_pkg::*;

	gn2_entry_t push_entry;
	gn2_entry_t head;
	logic       push;
	logic       pop;
	logic       fifo_full;
	logic       fifo_empty;

	// zero-wait config port
	assign pready = 1'b1;

	// front: seed register, hashing, point intake
	gn2_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.point      (point),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouples intake from output stalls
	gn2_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (fifo_full),
		.empty      (fifo_empty)
	);

	// back: dots, fade, blends, saturation, output register
	gn2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.fifo_empty (fifo_empty),
		.pop        (pop),
		.noise      (noise)
	);

endmodule

[bench/tb_gradient_noise_2d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_noise_2d: self-checking bench for the 2D gradient noise block
// Points go in through a queue-fed driver; every noise beat is checked against
// a bit-exact fixed-point predictor, through several hash seeds and stalls.
// ----------------------------------------------------------------------------
module tb_gradient_noise_2d;
	import gn2_pkg::*;

	// ---- bench constants ----------------------------------------------------
	localparam int     CELL_MUL     = 57;        // y weight in the corner hash
	localparam int     HASH_MASK    = 7;         // mod 256 then mod 8 = low 3 bits
	localparam logic [SEED_W-1:0] SEED_AT_RESET = SEED_W'(11);
	localparam longint UNIT         = longint'(1) << FRAC_BITS;        // 1.0
	localparam longint SAT          = longint'(1) << (FRAC_BITS + 1);  // 2.0
	localparam longint FADE_HALF    = longint'(1) << (2 * FRAC_BITS - 1);
	localparam int     GRAD_DX [8]  = '{1, -1, 0, 0, 1, -1, 1, -1};
	localparam int     GRAD_DY [8]  = '{0, 0, 1, -1, 1, 1, -1, -1};
	localparam logic [FRAC_BITS-1:0] FRAC_EDGES [4] = '{
		'0, '1, FRAC_BITS'(1) << (FRAC_BITS - 1), (FRAC_BITS'(1) << (FRAC_BITS - 1)) - 1'b1};
	localparam logic [INT_BITS-1:0] TOP_CELL = '1;

	// register map: seed at its index, and one index that decodes to nothing
	localparam logic [PADDR_W-1:0] SEED_ADDR  = {REG_SEED, 2'b00};
	localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_SEED, 2'b00};

	localparam int MAX_GAP       = 18;    // longest idle burst on either side
	localparam int CHOKE_CYCLES  = 80;    // long output hold-off, fills the queue
	localparam int QUIET_LIMIT   = 1000;  // cycles with no beat before giving up
	localparam int TAIL_CYCLES   = 24;    // settle time after the last result
	localparam int MAX_REPORTS   = 20;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

	// ---- clock, reset, channels ---------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gn2_point_if point_ch ();
	gn2_noise_if noise_ch ();

	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	gradient_noise_2d DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.point   (point_ch),
		.noise   (noise_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// ---- bench state --------------------------------------------------------
	point_t                  pending_points[$];  // points not yet offered
	logic signed [OUT_W-1:0] noise_due[$];       // predicted results, in order
	logic [SEED_W-1:0]       cfg_seed;           // predictor's copy of hash_seed
	int                      pts_sent;           // beats put on the channel
	int                      pts_accepted;       // beats taken by the block
	int                      errors;
	bit                      src_bursty;         // sender idles at random
	bit                      snk_bursty;         // receiver stalls at random
	bit                      sender_hold;        // sender stops offering
	int                      choke_req;          // bumped to ask for a long stall

	// ---- predictor ----------------------------------------------------------
	// Dot of the corner's gradient with the offset (dx, dy) from that corner.
	// The cell index is the true integer, so cx+1 past the top cell just keeps
	// counting and the hash wraps modulo 256 like any other sum.
	function automatic longint corner_dot(longint cx, longint cy, longint dx, longint dy,
			logic [SEED_W-1:0] seed);
		int h;
		h = int'((cx + CELL_MUL * cy + longint'(seed)) & HASH_MASK);
		return GRAD_DX[h] * dx + GRAD_DY[h] * dy;
	endfunction

	// w*w*(3-2w), rounded half up back to FRAC_BITS fraction bits
	function automatic longint fade_weight(longint s);
		return (s * s * (3 * UNIT - 2 * s) + FADE_HALF) >>> (2 * FRAC_BITS);
	endfunction

	// a + round((b-a)*t); >>> on a signed value is floor, so +half gives half up
	function automatic longint blend(longint a, longint b, longint t);
		return a + (((b - a) * t + (UNIT >>> 1)) >>> FRAC_BITS);
	endfunction

	function automatic logic signed [OUT_W-1:0] noise_at(logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [SEED_W-1:0] seed);
		longint cx, cy, sx, sy, fx, fy, top, bot, r;
		cx  = longint'(x[COORD_W-1:FRAC_BITS]);
		cy  = longint'(y[COORD_W-1:FRAC_BITS]);
		sx  = longint'(x[FRAC_BITS-1:0]);
		sy  = longint'(y[FRAC_BITS-1:0]);
		fx  = fade_weight(sx);
		fy  = fade_weight(sy);
		top = blend(corner_dot(cx, cy, sx, sy, seed),
			corner_dot(cx + 1, cy, sx - UNIT, sy, seed), fx);
		bot = blend(corner_dot(cx, cy + 1, sx, sy - UNIT, seed),
			corner_dot(cx + 1, cy + 1, sx - UNIT, sy - UNIT, seed), fx);
		r   = blend(top, bot, fy);
		if (r > SAT)
			r = SAT;
		else if (r < -SAT)
			r = -SAT;
		return OUT_W'(r);
	endfunction

	// ---- point driver (falling edge) ----------------------------------------
	// A beat on the channel is done once the monitor has counted it; only then
	// is the next point loaded or valid dropped for an idle burst.
	always @(negedge clk) begin : point_driver
		point_t p;
		logic   nv;
		int     src_gap;
		if (!arst_n) begin
			point_ch.valid <= 1'b0;
			src_gap = 0;
		end else if (!point_ch.valid || pts_accepted == pts_sent) begin
			nv = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
			end else if (!sender_hold && pending_points.size() != 0) begin
				p = pending_points.pop_front();
				point_ch.x_coord <= p.x;
				point_ch.y_coord <= p.y;
				pts_sent++;
				nv = 1'b1;
				if (src_bursty && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, MAX_GAP);
			end
			point_ch.valid <= nv;
		end
	end

	// ---- noise ready driver (falling edge) ----------------------------------
	// Random stall bursts, plus a long hold-off counted here when requested.
	always @(negedge clk) begin : noise_ready_driver
		logic rdy;
		int   snk_gap;
		int   choke_left;
		int   choke_seen;
		if (!arst_n) begin
			noise_ch.ready <= 1'b0;
			snk_gap    = 0;
			choke_left = 0;
			choke_seen = 0;
		end else begin
			if (choke_seen != choke_req) begin
				choke_seen = choke_req;
				choke_left = CHOKE_CYCLES;
			end
			rdy = 1'b0;
			if (choke_left > 0) begin
				choke_left--;
			end else if (snk_gap > 0) begin
				snk_gap--;
			end else begin
				rdy = 1'b1;
				if (snk_bursty && $urandom_range(0, 6) == 0)
					snk_gap = $urandom_range(1, MAX_GAP);
			end
			noise_ch.ready <= rdy;
		end
	end

	// ---- monitors (rising edge) ---------------------------------------------
	// Predict at the point beat, with the seed in force at that moment.
	always @(posedge clk) begin
		if (arst_n && point_ch.valid && point_ch.ready) begin
			noise_due.push_back(noise_at(point_ch.x_coord, point_ch.y_coord, cfg_seed));
			pts_accepted++;
		end
	end

	always @(posedge clk) begin : noise_checker
		logic signed [OUT_W-1:0] want;
		if (arst_n && noise_ch.valid && noise_ch.ready) begin
			if (noise_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: noise_value beat with nothing pending, expected none, got %0d",
						$time, noise_ch.noise_value);
			end else begin
				want = noise_due.pop_front();
				if (noise_ch.noise_value !== want) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: noise_value mismatch, expected %0d, got %0d",
							$time, want, noise_ch.noise_value);
				end
			end
		end
	end

	// ---- watchdog -----------------------------------------------------------
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else if ((point_ch.valid && point_ch.ready) || (noise_ch.valid && noise_ch.ready)
				|| (psel && penable && pready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ---- register access ----------------------------------------------------
	// Setup then access; the write lands at the edge where pready is seen.
	task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[PADDR_W-1:2] == REG_SEED)
			cfg_seed = data[SEED_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_check(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			errors++;
			$display("%0t: register read at 0x%0h, expected 0x%0h, got 0x%0h",
				$time, addr, want, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ---- stimulus helpers ---------------------------------------------------
	task automatic queue_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		point_t p;
		p.x = x;
		p.y = y;
		pending_points.push_back(p);
	endtask

	// Mostly full-range points; some in the first few cells so that the hash
	// neighborhood repeats; some with fraction edges and the top cell.
	task automatic queue_random(int n);
		point_t p;
		int     kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			p.x  = COORD_W'($urandom);
			p.y  = COORD_W'($urandom);
			if (kind < 2) begin
				p.x[COORD_W-1:FRAC_BITS] = INT_BITS'($urandom_range(0, 9));
				p.y[COORD_W-1:FRAC_BITS] = INT_BITS'($urandom_range(0, 9));
			end else if (kind < 3) begin
				p.x[FRAC_BITS-1:0] = FRAC_EDGES[$urandom_range(0, 3)];
				p.y[FRAC_BITS-1:0] = FRAC_EDGES[$urandom_range(0, 3)];
				if ($urandom_range(0, 1))
					p.x[COORD_W-1:FRAC_BITS] = TOP_CELL;
				if ($urandom_range(0, 1))
					p.y[COORD_W-1:FRAC_BITS] = TOP_CELL;
			end
			pending_points.push_back(p);
		end
	endtask

	// Every point gives one result, so no beat in flight and nothing due
	// means the block is idle.
	task automatic wait_results_in();
		do @(negedge clk); while (point_ch.valid || noise_due.size() != 0);
	endtask

	task automatic wait_drained();
		while (pending_points.size() != 0)
			@(negedge clk);
		wait_results_in();
	endtask

	// ---- test sequence ------------------------------------------------------
	initial begin : sequencer
		int mark;
		point_ch.valid   = 1'b0;
		point_ch.x_coord = '0;
		point_ch.y_coord = '0;
		noise_ch.ready   = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		arst_n           = 1'b0;
		cfg_seed         = SEED_AT_RESET;
		pts_sent         = 0;
		pts_accepted     = 0;
		errors           = 0;
		src_bursty       = 1'b1;
		snk_bursty       = 1'b1;
		sender_hold      = 1'b0;
		choke_req        = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// seed comes up at its reset value
		reg_check(SEED_ADDR, PDATA_W'(SEED_AT_RESET));

		// directed: corners of the coordinate space, fraction extremes,
		// the top cell (corner hash past the last cell), and cells 0..7 in a
		// row, which walk the hash through all eight gradients
		queue_point('0, '0);
		queue_point('1, '1);
		queue_point('1, '0);
		queue_point('0, '1);
		queue_point(COORD_W'({FRAC_BITS{1'b1}}), COORD_W'({FRAC_BITS{1'b1}}));
		queue_point(COORD_W'(FRAC_EDGES[2]), COORD_W'(FRAC_EDGES[2]));
		queue_point(COORD_W'(FRAC_EDGES[3]), COORD_W'(1));
		queue_point({TOP_CELL, FRAC_EDGES[0]}, {TOP_CELL, FRAC_EDGES[1]});
		for (int k = 0; k < 8; k++)
			queue_point({INT_BITS'(k), 12'h555}, {INT_BITS'(0), 12'hAAA});
		wait_drained();

		// seed at its low extreme
		reg_write(SEED_ADDR, PDATA_W'(0));
		queue_random(250);
		wait_drained();

		// seed at its high extreme; sender runs flat out while the output is
		// held off, so the queue and pipeline fill and the input stalls
		reg_write(SEED_ADDR, PDATA_W'({SEED_W{1'b1}}));
		reg_check(SEED_ADDR, PDATA_W'({SEED_W{1'b1}}));
		src_bursty = 1'b0;
		queue_random(250);
		choke_req++;
		wait_drained();
		src_bursty = 1'b1;

		// a write to an index that decodes to nothing leaves the seed alone
		reg_write(SPARE_ADDR, PDATA_W'(32'h0000_00A5));
		reg_check(SEED_ADDR, PDATA_W'({SEED_W{1'b1}}));

		// random seed; sender stops partway until every result is back
		reg_write(SEED_ADDR, PDATA_W'($urandom_range(1, 254)));
		mark = pts_accepted + 120;
		queue_random(300);
		while (pts_accepted < mark)
			@(negedge clk);
		sender_hold = 1'b1;
		wait_results_in();
		sender_hold = 1'b0;
		wait_drained();

		reg_write(SEED_ADDR, PDATA_W'($urandom_range(1, 254)));
		queue_random(300);
		wait_drained();

		reg_write(SEED_ADDR, PDATA_W'(128));
		queue_random(400);
		wait_drained();

		// back to the reset seed, with both sides streaming without gaps
		reg_write(SEED_ADDR, PDATA_W'(SEED_AT_RESET));
		src_bursty = 1'b0;
		snk_bursty = 1'b0;
		queue_random(250);
		wait_drained();

		// let any stray beat show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
